// ----- rtl/sfu_pkg.sv -----
// ----------------------------------------------------------------------------
// sfu_pkg
// shared widths, codes and types of the spring force pipeline
// ----------------------------------------------------------------------------
package sfu_pkg;

    localparam int FRAC_BITS = 16;

    localparam int POS_W  = 32;                 // position and force words
    localparam int D_W    = POS_W + 1;          // magnitude of a difference
    localparam int SQ_W   = 2 * D_W;            // sum of three squares
    localparam int LEN_W  = D_W;                // floor square root
    localparam int K_W    = 32;
    localparam int REST_W = 31;
    localparam int EXT_W  = LEN_W + 1;          // signed extension
    localparam int E_W    = LEN_W;              // magnitude of extension
    localparam int ADK_W  = D_W + K_W;
    localparam int LO_W   = 32;                 // low chunk of a split product
    localparam int HI_W   = ADK_W - LO_W;
    localparam int NUM_W  = ADK_W + E_W;
    localparam int DEN_W  = LEN_W + FRAC_BITS;
    localparam int Q_W    = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REST = 2'd2;

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_ANCHOR = 2'd1;
    localparam logic [1:0] MODE_BUNGEE = 2'd2;

    localparam logic [POS_W-1:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] NEG_LIM = 32'h8000_0000;

    typedef logic [2:0][POS_W-1:0] t_vec3;

    // per-lane data carried beside the length computation
    typedef struct packed {
        logic [2:0][ADK_W-1:0] adk;
        logic [2:0]            dneg;
    } t_side;

    // per-item control carried through the divider
    typedef struct packed {
        logic [2:0] dneg;
        logic       eneg;
        logic       quiet;
    } t_frc;

    typedef struct packed {
        t_vec3 force_v;
        logic  applied;
        logic  saturated;
    } t_res;

endpackage

// ----- rtl/spring_force_unit.sv -----
// ----------------------------------------------------------------------------
// spring_force_unit
// hooke's law spring force on a particle, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   slave stream: one transaction carries a particle position and the
//   position of the spring's other end; master stream: one transaction
//   carries the force on the particle plus applied and saturated flags
//   config port: write spring_mode, spring_const and rest_length by index
//   while no transaction is in flight
//   stages: 3 difference/square stages, 33 square root stages,
//   3 numerator stages, 34 divide and saturate stages, 1 output register
//   throughput: one transaction per cycle while the skid entry is free;
//   the 33-bit square root and the 32-bit quotient each take one bit
//   per stage
//   reset: synchronous, clears all valid bits, the skid entry and the
//   configuration registers (plain spring, zero constant, zero rest length)
//   stall: a result that is not taken waits in the output register; the
//   next one goes into a skid entry, and only then does the pipeline and
//   o_s_axis_tready hold until the receiver takes the waiting result
// ----------------------------------------------------------------------------
module spring_force_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sfu_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // pos_x, pos_y, pos_z, end_x, end_y, end_z, 32 bits each
    input  logic [191:0]                        i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // force_x, force_y, force_z (32 each), applied, saturated, 6 zero bits
    output logic [103:0]                        o_m_axis_tdata
);
    import sfu_pkg::*;

    // configuration registers
    logic [1:0]        r_mode;
    logic [K_W-1:0]    r_k;
    logic [REST_W-1:0] r_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_k    <= '0;
            r_rest <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: r_mode <= i_cfg_wdata[1:0];
                CFG_K:    r_k    <= i_cfg_wdata[K_W-1:0];
                CFG_REST: r_rest <= i_cfg_wdata[REST_W-1:0];
                default:  ;
            endcase
        end
    end

    // whole pipeline advances while the skid entry is free
    logic w_en;
    logic r_skid_vld;
    assign w_en = !r_skid_vld;
    assign o_s_axis_tready = w_en;

    t_vec3 w_pos;
    t_vec3 w_end;
    assign w_pos = {i_s_axis_tdata[95:64],  i_s_axis_tdata[63:32],  i_s_axis_tdata[31:0]};
    assign w_end = {i_s_axis_tdata[191:160], i_s_axis_tdata[159:128], i_s_axis_tdata[127:96]};

    logic              w_d_vld;
    logic [SQ_W-1:0]   w_sum;
    t_side             w_d_side;

    sfu_delta u_delta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_axis_tvalid),
        .i_pos   (w_pos),
        .i_end   (w_end),
        .i_k     (r_k),
        .o_vld   (w_d_vld),
        .o_sum   (w_sum),
        .o_side  (w_d_side)
    );

    logic              w_r_vld;
    logic [LEN_W-1:0]  w_len;
    t_side             w_r_side;

    sfu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d_vld),
        .i_sum   (w_sum),
        .i_side  (w_d_side),
        .o_vld   (w_r_vld),
        .o_len   (w_len),
        .o_side  (w_r_side)
    );

    logic                   w_s_vld;
    logic [2:0][NUM_W-1:0]  w_num;
    logic [DEN_W-1:0]       w_den;
    t_frc                   w_frc;

    sfu_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_r_vld),
        .i_len   (w_len),
        .i_side  (w_r_side),
        .i_mode  (r_mode),
        .i_rest  (r_rest),
        .o_vld   (w_s_vld),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_frc   (w_frc)
    );

    logic  w_p_vld;
    t_res  w_p_res;

    sfu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s_vld),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_frc   (w_frc),
        .o_vld   (w_p_vld),
        .o_res   (w_p_res)
    );

    // output register with one skid entry behind it
    logic  r_out_vld;
    t_res  r_out;
    t_res  r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_p_vld;
            end
        end else if (w_en && w_p_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_axis_tready) begin
            r_out <= r_skid_vld ? r_skid : w_p_res;
        end else if (w_en && w_p_vld) begin
            r_skid <= w_p_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'b0, r_out.saturated, r_out.applied,
                              r_out.force_v[2], r_out.force_v[1], r_out.force_v[0]};

`ifndef SYNTHESIS
    // skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid without output result");

    // a stalled result never gets overwritten by a pipeline result
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_axis_tready && !r_skid_vld) |=> $stable(r_out))
        else $error("waiting result overwritten");

    // an item with no spring action carries no force and no clip flag
    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.applied) |->
            (r_out.force_v == '0 && !r_out.saturated))
        else $error("force on an item without spring action");
`endif

endmodule

// ----- rtl/sfu_delta.sv -----
// ----------------------------------------------------------------------------
// sfu_delta
// difference vector, squares, sum of squares and |d|*k per lane
// ----------------------------------------------------------------------------
module sfu_delta (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  sfu_pkg::t_vec3            i_pos,
    input  sfu_pkg::t_vec3            i_end,
    input  logic [sfu_pkg::K_W-1:0]   i_k,
    output logic                      o_vld,
    output logic [sfu_pkg::SQ_W-1:0]  o_sum,
    output sfu_pkg::t_side            o_side
);
    import sfu_pkg::*;

    logic [2:0][D_W-1:0]   w_d;
    logic [2:0][D_W-1:0]   r_ad;
    logic [2:0]            r_dneg_a;
    logic [2:0]            r_dneg_b;
    logic [2:0][SQ_W-1:0]  r_sq;
    logic [2:0][ADK_W-1:0] r_adk;
    logic [SQ_W-1:0]       r_sum;
    t_side                 r_side;
    logic [2:0]            r_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = {i_pos[i][POS_W-1], i_pos[i]} - {i_end[i][POS_W-1], i_end[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ad[i]     <= w_d[i][D_W-1] ? D_W'(-w_d[i]) : w_d[i];
                r_dneg_a[i] <= w_d[i][D_W-1];
                r_sq[i]     <= r_ad[i] * r_ad[i];
                r_adk[i]    <= r_ad[i] * i_k;
            end
            r_dneg_b    <= r_dneg_a;
            r_sum       <= r_sq[0] + r_sq[1] + r_sq[2];
            r_side.adk  <= r_adk;
            r_side.dneg <= r_dneg_b;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_sum  = r_sum;
    assign o_side = r_side;

endmodule

// ----- rtl/sfu_sqrt.sv -----
// ----------------------------------------------------------------------------
// sfu_sqrt
// floor square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module sfu_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [sfu_pkg::SQ_W-1:0]   i_sum,
    input  sfu_pkg::t_side             i_side,
    output logic                       o_vld,
    output logic [sfu_pkg::LEN_W-1:0]  o_len,
    output sfu_pkg::t_side             o_side
);
    import sfu_pkg::*;

    logic              r_vld  [1:LEN_W];
    logic [SQ_W-1:0]   r_rem  [1:LEN_W];
    logic [LEN_W-1:0]  r_root [1:LEN_W];
    t_side             r_side [1:LEN_W];

    for (genvar s = 1; s <= LEN_W; s++) begin : g_stg
        localparam int B = LEN_W - s;
        logic             w_vld_in;
        logic [SQ_W-1:0]  w_rem_in;
        logic [LEN_W-1:0] w_root_in;
        t_side            w_side_in;
        logic [SQ_W:0]    w_trial;
        logic [SQ_W:0]    w_diff;
        logic             w_take;

        if (s == 1) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_rem_in  = i_sum;
            assign w_root_in = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_side_in = r_side[s-1];
        end

        // (2*root + bit) * bit, with root holding only bits above this one
        assign w_trial = ((SQ_W+1)'(w_root_in) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));
        assign w_diff  = {1'b0, w_rem_in} - w_trial;
        assign w_take  = !w_diff[SQ_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_take ? w_diff[SQ_W-1:0] : w_rem_in;
                r_root[s] <= w_take ? (w_root_in | (LEN_W'(1) << B)) : w_root_in;
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[LEN_W];
    assign o_len  = r_root[LEN_W];
    assign o_side = r_side[LEN_W];

endmodule

// ----- rtl/sfu_scale.sv -----
// ----------------------------------------------------------------------------
// sfu_scale
// extension, mode handling, numerator |d|*k*e per lane and the denominator
// ----------------------------------------------------------------------------
module sfu_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [sfu_pkg::LEN_W-1:0]   i_len,
    input  sfu_pkg::t_side              i_side,
    input  logic [1:0]                  i_mode,
    input  logic [sfu_pkg::REST_W-1:0]  i_rest,
    output logic                        o_vld,
    output logic [2:0][sfu_pkg::NUM_W-1:0] o_num,
    output logic [sfu_pkg::DEN_W-1:0]   o_den,
    output sfu_pkg::t_frc               o_frc
);
    import sfu_pkg::*;

    logic [EXT_W-1:0]       w_ext;
    logic                   w_ext_neg;
    logic [2:0]             r_vld;
    logic [E_W-1:0]         r_e;
    logic [2:0][ADK_W-1:0]  r_adk;
    logic [DEN_W-1:0]       r_den  [1:3];
    t_frc                   r_frc  [1:3];
    logic [2:0][HI_W+E_W-1:0] r_ph;
    logic [2:0][LO_W+E_W-1:0] r_pl;
    logic [2:0][NUM_W-1:0]  r_num;

    assign w_ext     = {1'b0, i_len} - EXT_W'(i_rest);
    assign w_ext_neg = w_ext[EXT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: extension and flags
            r_e          <= w_ext_neg ? E_W'(-w_ext) : w_ext[E_W-1:0];
            r_adk        <= i_side.adk;
            r_den[1]     <= {i_len, {FRAC_BITS{1'b0}}};
            r_frc[1].dneg  <= i_side.dneg;
            r_frc[1].eneg  <= (i_mode == MODE_ANCHOR) && w_ext_neg;
            r_frc[1].quiet <= (i_len == '0) ||
                              ((i_mode == MODE_BUNGEE) && (w_ext_neg || (w_ext == '0)));
            // stage 2: split products
            for (int i = 0; i < 3; i++) begin
                r_ph[i] <= r_adk[i][ADK_W-1:LO_W] * r_e;
                r_pl[i] <= r_adk[i][LO_W-1:0] * r_e;
            end
            r_den[2] <= r_den[1];
            r_frc[2] <= r_frc[1];
            // stage 3: recombine
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= {r_ph[i], {LO_W{1'b0}}} + NUM_W'(r_pl[i]);
            end
            r_den[3] <= r_den[2];
            r_frc[3] <= r_frc[2];
        end
    end

    assign o_vld = r_vld[2];
    assign o_num = r_num;
    assign o_den = r_den[3];
    assign o_frc = r_frc[3];

endmodule

// ----- rtl/sfu_div.sv -----
// ----------------------------------------------------------------------------
// sfu_div
// restoring divide, one quotient bit per stage, then sign and saturation
// ----------------------------------------------------------------------------
module sfu_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [2:0][sfu_pkg::NUM_W-1:0] i_num,
    input  logic [sfu_pkg::DEN_W-1:0]      i_den,
    input  sfu_pkg::t_frc                  i_frc,
    output logic                           o_vld,
    output sfu_pkg::t_res                  o_res
);
    import sfu_pkg::*;

    localparam int NS = Q_W;

    logic                  r_vld  [0:NS+1];
    logic [2:0][NUM_W-1:0] r_rem  [0:NS];
    logic [2:0][Q_W-1:0]   r_q    [1:NS];
    logic [2:0]            r_ovf  [0:NS];
    logic [DEN_W-1:0]      r_den  [0:NS];
    t_frc                  r_frc  [0:NS];
    t_res                  r_res;

    // stage 0: a quotient of 2^32 or more clips whatever its sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ovf[0][i] <= i_num[i] >= NUM_W'({i_den, {Q_W{1'b0}}});
            end
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_frc[0] <= i_frc;
        end
    end

    for (genvar s = 1; s <= NS; s++) begin : g_stg
        localparam int J = NS - s;
        logic [NUM_W-1:0]       w_dsh;
        logic [2:0][NUM_W:0]    w_diff;
        logic [2:0][Q_W-1:0]    w_q_in;

        assign w_dsh = NUM_W'(r_den[s-1]) << J;

        if (s == 1) begin : g_first
            assign w_q_in = '0;
        end else begin : g_next
            assign w_q_in = r_q[s-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_diff[i] = {1'b0, r_rem[s-1][i]} - {1'b0, w_dsh};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (!w_diff[i][NUM_W]) begin
                        r_rem[s][i] <= w_diff[i][NUM_W-1:0];
                        r_q[s][i]   <= w_q_in[i] | (Q_W'(1) << J);
                    end else begin
                        r_rem[s][i] <= r_rem[s-1][i];
                        r_q[s][i]   <= w_q_in[i];
                    end
                end
                r_ovf[s] <= r_ovf[s-1];
                r_den[s] <= r_den[s-1];
                r_frc[s] <= r_frc[s-1];
            end
        end
    end

    // last stage: direction, clipping, zero for a quiet item
    logic [2:0]   w_fneg;
    logic [2:0]   w_big;
    t_res         w_res;

    always_comb begin
        w_res = '0;
        for (int i = 0; i < 3; i++) begin
            w_fneg[i] = (!r_frc[NS].dneg[i]) != r_frc[NS].eneg;
            w_big[i]  = r_ovf[NS][i] ||
                        (w_fneg[i] ? (r_q[NS][i][Q_W-1] && (|r_q[NS][i][Q_W-2:0]))
                                   : r_q[NS][i][Q_W-1]);
            if (w_big[i]) begin
                w_res.force_v[i] = w_fneg[i] ? NEG_LIM : POS_LIM;
            end else begin
                w_res.force_v[i] = w_fneg[i] ? POS_W'(-r_q[NS][i]) : r_q[NS][i];
            end
        end
        w_res.applied   = 1'b1;
        w_res.saturated = |w_big;
        if (r_frc[NS].quiet) begin
            w_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[NS+1] <= 1'b0;
        end else if (i_en) begin
            r_vld[NS+1] <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= w_res;
        end
    end

    assign o_vld = r_vld[NS+1];
    assign o_res = r_res;

endmodule

// ----- tb/sfu_checker.sv -----
// ----------------------------------------------------------------------------
// sfu_checker
// predicts the spring force of every accepted transaction and compares it
// field by field with the results leaving the block, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sfu_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfu_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic [191:0]                   i_s_axis_tdata,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [103:0]                   i_m_axis_tdata,
    output int                             o_fail_cnt,
    output int                             o_pending
);
    import sfu_pkg::*;

    logic [1:0]        mode_q;
    logic [K_W-1:0]    k_q;
    logic [REST_W-1:0] rest_q;
    t_res              force_q[$];
    string             force_name[3] = '{"force_x", "force_y", "force_z"};

    assign o_pending = force_q.size();

    function automatic t_res spring_force(logic [191:0] pts);
        t_res   r;
        logic signed [33:0] d;
        logic [32:0]  ad[3];
        logic         dn[3];
        logic [67:0]  sq;
        logic [33:0]  len, c;
        logic signed [35:0] ext;
        logic [33:0]  e;
        logic         eneg, fneg;
        logic [191:0] num;
        logic [191:0] q;
        logic [31:0]  lim;
        r = '0;
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            d = $signed(pts[32*i +: 32]) - $signed(pts[32*(i+3) +: 32]);
            dn[i] = d < 0;
            ad[i] = dn[i] ? 33'(-d) : 33'(d);
            sq += 68'(ad[i]) * 68'(ad[i]);
        end
        // bitwise floor square root
        len = '0;
        for (int b = 33; b >= 0; b--) begin
            c = len | (34'd1 << b);
            if (68'(c) * 68'(c) <= sq) len = c;
        end
        if (len == 0) return r;
        ext = $signed({2'b0, len}) - $signed({5'b0, rest_q});
        if (mode_q == MODE_BUNGEE && ext <= 0) return r;
        e = ext < 0 ? 34'(-ext) : 34'(ext);
        eneg = (mode_q == MODE_ANCHOR) && ext < 0;
        for (int i = 0; i < 3; i++) begin
            // k*|d| is reduced to 64 bits, which holds it without loss
            num = 192'(64'(64'(ad[i]) * 64'(k_q))) * 192'(e);
            q = num / (192'(len) << FRAC_BITS);
            fneg = !dn[i] != eneg;
            lim = fneg ? NEG_LIM : POS_LIM;
            if (q > 192'(lim)) begin
                q = 192'(lim);
                r.saturated = 1'b1;
            end
            r.force_v[i] = fneg ? 32'(-q[31:0]) : q[31:0];
        end
        r.applied = 1'b1;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        t_res want, got;
        int   errs;
        if (!i_rst_n) begin
            mode_q <= MODE_PLAIN;
            k_q <= '0;
            rest_q <= '0;
            o_fail_cnt <= 0;
            force_q.delete();
        end else begin
            errs = 0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: mode_q <= i_cfg_wdata[1:0];
                    CFG_K:    k_q <= i_cfg_wdata;
                    CFG_REST: rest_q <= i_cfg_wdata[REST_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                force_q = {force_q, spring_force(i_s_axis_tdata)};
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.force_v = i_m_axis_tdata[95:0];
                got.applied = i_m_axis_tdata[96];
                got.saturated = i_m_axis_tdata[97];
                if (force_q.size() == 0) begin
                    $error("result with nothing expected");
                    errs++;
                end else begin
                    want = force_q.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (got.force_v[i] !== want.force_v[i]) begin
                            $error("%s: expected %h, got %h", force_name[i],
                                   want.force_v[i], got.force_v[i]);
                            errs++;
                        end
                    if (got.applied !== want.applied) begin
                        $error("applied: expected %b, got %b", want.applied, got.applied);
                        errs++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $error("saturated: expected %b, got %b",
                               want.saturated, got.saturated);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                o_fail_cnt <= o_fail_cnt + errs;
        end
    end
endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// stimulus for the spring force unit: directed corner cases then random
// position pairs across all modes, with idle and stall phases
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import sfu_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid, s_tready;
    logic [191:0]          s_tdata;
    logic                  m_tvalid, m_tready;
    logic [103:0]          m_tdata;
    int                    fail_cnt, pending;
    int                    idle_pct, stall_pct;

    always begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    spring_force_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_wdata(cfg_wdata), .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    sfu_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_wdata(cfg_wdata), .i_s_axis_tvalid(s_tvalid),
        .i_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    // receiver stalls on its own, in whatever phase is current
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // one configuration write, only when nothing is in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    task automatic set_spring(logic [1:0] m, logic [31:0] k, logic [30:0] r);
        drain();
        write_reg(CFG_MODE, 32'(m));
        write_reg(CFG_K, k);
        write_reg(CFG_REST, 32'(r));
        cfg_we <= 1'b0;
    endtask

    // one transaction, with random idle cycles ahead of it
    task automatic send_pair(logic [95:0] p, logic [95:0] q);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {q, p};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int span);
        case ($urandom_range(3))
            0: return $urandom;                            // full range
            1: return 32'($signed($urandom_range(2 * span)) - span);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(64)) - 32) <<< 16;
        endcase
    endfunction

    task automatic random_pairs(int n);
        logic [95:0] p, q;
        int span;
        for (int j = 0; j < n; j++) begin
            span = $urandom_range(1) ? 32'h0004_0000 : 32'h0100_0000;
            for (int i = 0; i < 3; i++) begin
                p[32*i +: 32] = rand_coord(span);
                // mostly near the other end so extension stays meaningful
                q[32*i +: 32] = $urandom_range(3) == 0 ? rand_coord(span)
                              : p[32*i +: 32] + 32'($signed($urandom_range(2 * span)) - span);
            end
            if ($urandom_range(19) == 0) q = p;            // zero length
            send_pair(p, q);
        end
    endtask

    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [1:0]  m;
        logic [31:0] k;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b1;
        idle_pct = 0; stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, zero length, extremes, every mode
        send_pair('0, '0);
        send_pair({3{32'h0001_0000}}, '0);
        set_spring(MODE_PLAIN, 32'h0001_0000, 31'h0002_0000);
        send_pair({32'd0, 32'd0, 32'h0001_0000}, '0);       // compressed
        send_pair({32'd0, 32'h0005_0000, 32'd0}, '0);       // stretched
        send_pair({3{32'h7FFF_FFFF}}, {3{32'h8000_0000}});
        send_pair({3{32'h8000_0000}}, {3{32'h7FFF_FFFF}});
        send_pair({32'd0, 32'd0, 32'h0002_0000}, '0);       // zero extension
        set_spring(MODE_ANCHOR, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_pair({32'h0000_0001, 32'd0, 32'd0}, '0);
        send_pair({3{32'h7FFF_FFFF}}, {3{32'h8000_0000}});
        send_pair({32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000}, '0);
        set_spring(MODE_BUNGEE, 32'h0002_8000, 31'h0003_0000);
        send_pair({32'd0, 32'd0, 32'h0002_0000}, '0);       // slack
        send_pair({32'd0, 32'd0, 32'h0003_0000}, '0);       // exactly rest
        send_pair({32'd0, 32'hFFF8_0000, 32'h0003_0000}, '0);
        set_spring(2'd3, 32'h0001_0000, 31'h0001_0000);     // unused mode
        send_pair({32'd0, 32'h0004_0000, 32'hFFFD_0000}, '0);
        set_spring(MODE_ANCHOR, 32'd0, 31'd0);              // zero constant
        send_pair({32'h1234_5678, 32'd5, 32'hFFFF_0000}, '0);

        // random: four pacing phases, settings change between chunks
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 74 : 11) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 74 : 11) : 0;
            for (int c = 0; c < 4; c++) begin
                m = $urandom_range(3);
                case ($urandom_range(3))
                    0: k = $urandom;
                    1: k = $urandom_range(32'h0004_0000);
                    2: k = 32'hFFFF_FFFF;
                    default: k = 32'h0001_0000;
                endcase
                set_spring(m, k, $urandom_range(3) == 0 ? 31'($urandom)
                                                         : 31'($urandom_range(32'h0400_0000)));
                random_pairs(34);
            end
        end
        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/sfu_pkg.sv
rtl/sfu_delta.sv
rtl/sfu_sqrt.sv
rtl/sfu_scale.sv
rtl/sfu_div.sv
rtl/spring_force_unit.sv
tb/sfu_checker.sv
tb/tb.sv
